// ===== design/grbp_pkg.sv =====
// ----------------------------------------------------------------------------
// grbp_pkg: shared types and codes for the genomic region bin painter
// Holds the command and result transaction types, region codes, painting
// operation codes and configuration register indexes.
// ----------------------------------------------------------------------------
package grbp_pkg;

    typedef struct packed {
        logic        mode;
        logic [4:0]  chrom_index;
        logic        chrom_known;
        logic        strand;
        logic [27:0] tx_start;
        logic [27:0] tx_end;
        logic [27:0] cds_start;
        logic [27:0] cds_end;
        logic [27:0] exon_start;
        logic [27:0] exon_end;
        logic        first_exon;
        logic [13:0] read_bin;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  region_code;
        logic [15:0] transcript_count;
    } result_t;

    localparam logic [3:0] RC_INTERGENIC = 4'd0;
    localparam logic [3:0] RC_PROMOTER   = 4'd1;
    localparam logic [3:0] RC_GENIC      = 4'd2;
    localparam logic [3:0] RC_DISTAL     = 4'd3;
    localparam logic [3:0] RC_PROXIMAL   = 4'd4;
    localparam logic [3:0] RC_UTR5       = 4'd5;
    localparam logic [3:0] RC_UTR3       = 4'd6;
    localparam logic [3:0] RC_CDS        = 4'd7;
    localparam logic [3:0] RC_INTRON     = 4'd8;

    // Painting operations, run in this order.
    localparam logic [2:0] OP_BASIC_PROM = 3'd0;
    localparam logic [2:0] OP_BASIC_GEN  = 3'd1;
    localparam logic [2:0] OP_FLANK_PROM = 3'd2;
    localparam logic [2:0] OP_FLANK_GEN  = 3'd3;
    localparam logic [2:0] OP_DISTAL     = 3'd4;
    localparam logic [2:0] OP_PROXIMAL   = 3'd5;
    localparam logic [2:0] OP_INTRON     = 3'd6;
    localparam logic [2:0] OP_EXON       = 3'd7;

    localparam logic [2:0] REG_WINDOW_RES     = 3'd0;
    localparam logic [2:0] REG_MAP_MODE       = 3'd1;
    localparam logic [2:0] REG_FLANK_SIZE     = 3'd2;
    localparam logic [2:0] REG_PROMOTER_SIZE  = 3'd3;
    localparam logic [2:0] REG_PROXIMAL_POINT = 3'd4;

    localparam int DIV_STEPS = 29;

endpackage

// ===== design/genomic_region_bin_painter.sv =====
// ----------------------------------------------------------------------------
// genomic_region_bin_painter
// Paints promoter, genic, distal, proximal, UTR, CDS and intron codes into a per-chromosome
// bin map from exon transactions, and reads single bins back.
// ----------------------------------------------------------------------------
// After reset the block clears its map, one entry per cycle, with busy
// high. A read transaction passes through a request state and a data
// state before its result. A mark transaction runs each enabled painting
// operation in turn: every position-to-bin conversion uses one shared
// bit-serial divider, a load step and then the divide steps (two
// conversions per operation, one for the intron, four for the exon). Each
// operation also passes through a selection state and a range check, and
// every bin in its range takes a read and a write step of read-modify-write
// on the single map port. A final conversion stores the exon end bin,
// followed by the result cycle. The result appears for one cycle on result
// with result_valid high and cannot be stalled, so the receiver must take it.
module genomic_region_bin_painter #(
    parameter int CHROM_COUNT    = 32,
    parameter int BINS_PER_CHROM = 16384
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  grbp_pkg::cmd_t     cmd,
    output logic               result_valid,
    output grbp_pkg::result_t  result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int DEPTH = CHROM_COUNT * BINS_PER_CHROM;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = (BINS_PER_CHROM > 1) ? $clog2(BINS_PER_CHROM) : 1;
    localparam int JW    = $clog2(BINS_PER_CHROM + 1);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RDREQ  = 4'd2;
    localparam logic [3:0] S_RDDATA = 4'd3;
    localparam logic [3:0] S_NEXT   = 4'd4;
    localparam logic [3:0] S_DLOAD  = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_WINIT  = 4'd7;
    localparam logic [3:0] S_WRD    = 4'd8;
    localparam logic [3:0] S_WWR    = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    // configuration
    logic [20:0] window_res_reg, flank_size_reg, promoter_size_reg, proximal_point_reg;
    logic [1:0]  map_mode_reg;
    logic        cfg_wr;

    // control and datapath
    logic [3:0]        state_reg, state_next;
    grbp_pkg::cmd_t    cmd_reg, cmd_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [AW-1:0]     row_base_reg, row_base_next;
    logic [7:0]        mask_reg, mask_next;
    logic [2:0]        op_reg, op_next;
    logic [1:0]        slot_reg, slot_next;
    logic              prev_tag_reg, prev_tag_next;
    logic [28:0]       mag_reg, mag_next;
    logic [21:0]       rem_reg, rem_next;
    logic              neg_reg, neg_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic signed [30:0] lo_reg, lo_next, hi_reg, hi_next;
    logic signed [30:0] cs_reg, cs_next, ce_reg, ce_next;
    logic [JW-1:0]     j_reg, j_next, hic_reg, hic_next;
    logic [27:0]       prev_reg, prev_next;
    logic [15:0]       tx_reg, tx_next;
    logic [3:0]        code_reg, code_next;

    // map memory
    logic [3:0]    mem [DEPTH];
    logic [3:0]    rdata_reg;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [3:0]    mem_wdata;

    // combinational helpers
    logic [20:0]        w_eff;
    logic signed [30:0] p1, p2, c1, c2, e1, e2, pp, xx, ff;
    logic signed [30:0] div_pos;
    logic [21:0]        rem_sh;
    logic signed [30:0] quot;
    logic               accept;
    logic               read_ok;
    logic [JW-1:0]      lo_c, hi_c;
    logic signed [30:0] jw;
    logic [3:0]         new_code;
    logic               paint_ok;

    function automatic logic [JW-1:0] clamp_bin(input logic signed [30:0] b);
        logic [JW-1:0] r;
        if (b < 0)
            r = '0;
        else if (b > 31'(BINS_PER_CHROM))
            r = JW'(BINS_PER_CHROM);
        else
            r = JW'(b);
        return r;
    endfunction

    function automatic logic read_ok_latched();
        return (32'(cmd_reg.chrom_index) < 32'(CHROM_COUNT))
            && (32'(cmd_reg.read_bin) < 32'(BINS_PER_CHROM));
    endfunction

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_res_reg     <= 21'd1;
            map_mode_reg       <= 2'd0;
            flank_size_reg     <= 21'd1000;
            promoter_size_reg  <= 21'd2500;
            proximal_point_reg <= 21'd1000;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                grbp_pkg::REG_WINDOW_RES:     window_res_reg     <= pwdata[20:0];
                grbp_pkg::REG_MAP_MODE:       map_mode_reg       <= pwdata[1:0];
                grbp_pkg::REG_FLANK_SIZE:     flank_size_reg     <= pwdata[20:0];
                grbp_pkg::REG_PROMOTER_SIZE:  promoter_size_reg  <= pwdata[20:0];
                grbp_pkg::REG_PROXIMAL_POINT: proximal_point_reg <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            grbp_pkg::REG_WINDOW_RES:     prdata = {11'd0, window_res_reg};
            grbp_pkg::REG_MAP_MODE:       prdata = {30'd0, map_mode_reg};
            grbp_pkg::REG_FLANK_SIZE:     prdata = {11'd0, flank_size_reg};
            grbp_pkg::REG_PROMOTER_SIZE:  prdata = {11'd0, promoter_size_reg};
            grbp_pkg::REG_PROXIMAL_POINT: prdata = {11'd0, proximal_point_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    // ---------------- operands ----------------
    assign w_eff = (window_res_reg == 21'd0) ? 21'd1 : window_res_reg;
    assign p1 = $signed({3'd0, cmd_reg.tx_start});
    assign p2 = $signed({3'd0, cmd_reg.tx_end});
    assign c1 = $signed({3'd0, cmd_reg.cds_start});
    assign c2 = $signed({3'd0, cmd_reg.cds_end});
    assign e1 = $signed({3'd0, cmd_reg.exon_start});
    assign e2 = $signed({3'd0, cmd_reg.exon_end});
    assign pp = $signed({10'd0, promoter_size_reg});
    assign xx = $signed({10'd0, proximal_point_reg});
    assign ff = $signed({10'd0, flank_size_reg});

    // Position handed to the divider for the current operation and slot.
    // Slot 0 is the low bound, slot 1 the high bound, slots 2 and 3 the
    // coding bounds of the exon operation.
    always_comb
    begin
        div_pos = e2;
        if (!prev_tag_reg)
        begin
            unique case (op_reg)
                grbp_pkg::OP_BASIC_PROM:
                    div_pos = (slot_reg == 2'd0) ? (cmd_reg.strand ? p2 : p1 - pp)
                                                 : (cmd_reg.strand ? p2 + pp : p1);
                grbp_pkg::OP_BASIC_GEN:
                    div_pos = (slot_reg == 2'd0) ? p1 : p2;
                grbp_pkg::OP_FLANK_PROM:
                    div_pos = (slot_reg == 2'd0) ? (cmd_reg.strand ? p2 - ff : p1 - ff)
                                                 : (cmd_reg.strand ? p2 + ff : p1 + ff);
                grbp_pkg::OP_FLANK_GEN:
                    div_pos = (slot_reg == 2'd0) ? (cmd_reg.strand ? p1 : p1 + ff)
                                                 : (cmd_reg.strand ? p2 - ff : p2);
                grbp_pkg::OP_DISTAL:
                    div_pos = (slot_reg == 2'd0)
                        ? (cmd_reg.strand ? p2 + xx + 31'sd1 : p1 - pp)
                        : (cmd_reg.strand ? p2 + pp : p1 - xx - 31'sd1);
                grbp_pkg::OP_PROXIMAL:
                    div_pos = (slot_reg == 2'd0) ? (cmd_reg.strand ? p2 : p1 - xx)
                                                 : (cmd_reg.strand ? p2 + xx : p1);
                grbp_pkg::OP_INTRON:
                    div_pos = e1;
                grbp_pkg::OP_EXON:
                begin
                    unique case (slot_reg)
                        2'd0: div_pos = e1;
                        2'd1: div_pos = e2;
                        2'd2: div_pos = c1;
                        2'd3: div_pos = c2;
                    endcase
                end
            endcase
        end
    end

    // One restoring division step per cycle; the quotient shifts into mag.
    assign rem_sh = {rem_reg[20:0], mag_reg[28]};
    assign quot   = neg_reg ? -$signed({2'd0, mag_reg}) : $signed({2'd0, mag_reg});

    assign lo_c = clamp_bin(lo_reg);
    assign hi_c = clamp_bin(hi_reg);
    assign jw   = $signed(31'(j_reg));

    // Read-modify-write decision for the bin under the walk.
    always_comb
    begin
        new_code = grbp_pkg::RC_INTERGENIC;
        paint_ok = 1'b1;
        unique case (op_reg)
            grbp_pkg::OP_BASIC_PROM, grbp_pkg::OP_FLANK_PROM:
                new_code = grbp_pkg::RC_PROMOTER;
            grbp_pkg::OP_BASIC_GEN, grbp_pkg::OP_FLANK_GEN:
            begin
                new_code = grbp_pkg::RC_GENIC;
                paint_ok = (rdata_reg != grbp_pkg::RC_PROMOTER);
            end
            grbp_pkg::OP_DISTAL:
                new_code = grbp_pkg::RC_DISTAL;
            grbp_pkg::OP_PROXIMAL:
                new_code = grbp_pkg::RC_PROXIMAL;
            grbp_pkg::OP_INTRON:
            begin
                new_code = grbp_pkg::RC_INTRON;
                paint_ok = !(rdata_reg == grbp_pkg::RC_DISTAL
                          || rdata_reg == grbp_pkg::RC_PROXIMAL
                          || rdata_reg == grbp_pkg::RC_UTR5
                          || rdata_reg == grbp_pkg::RC_UTR3
                          || rdata_reg == grbp_pkg::RC_CDS);
            end
            grbp_pkg::OP_EXON:
            begin
                paint_ok = !(rdata_reg == grbp_pkg::RC_DISTAL
                          || rdata_reg == grbp_pkg::RC_PROXIMAL);
                if (jw < cs_reg)
                    new_code = cmd_reg.strand ? grbp_pkg::RC_UTR3 : grbp_pkg::RC_UTR5;
                else if (jw > ce_reg)
                    new_code = cmd_reg.strand ? grbp_pkg::RC_UTR5 : grbp_pkg::RC_UTR3;
                else
                    new_code = grbp_pkg::RC_CDS;
            end
        endcase
    end

    assign accept  = start && (state_reg == S_IDLE);
    assign read_ok = (32'(cmd.chrom_index) < 32'(CHROM_COUNT))
                  && (32'(cmd.read_bin) < 32'(BINS_PER_CHROM));

    assign mem_addr  = (state_reg == S_CLEAR) ? clr_reg
                                              : row_base_reg + AW'(j_reg[BW-1:0]);
    assign mem_we    = (state_reg == S_CLEAR) || ((state_reg == S_WWR) && paint_ok);
    assign mem_wdata = (state_reg == S_CLEAR) ? grbp_pkg::RC_INTERGENIC : new_code;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rdata_reg <= mem[mem_addr];
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        clr_next      = clr_reg;
        row_base_next = row_base_reg;
        mask_next     = mask_reg;
        op_next       = op_reg;
        slot_next     = slot_reg;
        prev_tag_next = prev_tag_reg;
        mag_next      = mag_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        cnt_next      = cnt_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        cs_next       = cs_reg;
        ce_next       = ce_reg;
        j_next        = j_reg;
        hic_next      = hic_reg;
        prev_next     = prev_reg;
        tx_next       = tx_reg;
        code_next     = code_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next      = cmd;
                    row_base_next = AW'(cmd.chrom_index) * AW'(BINS_PER_CHROM);
                    code_next     = grbp_pkg::RC_INTERGENIC;
                    if (cmd.mode)
                    begin
                        j_next     = read_ok ? JW'(cmd.read_bin) : '0;
                        state_next = S_RDREQ;
                    end
                    else
                    begin
                        if (cmd.first_exon && tx_reg != 16'hFFFF)
                            tx_next = tx_reg + 16'd1;
                        mask_next = '0;
                        if (cmd.chrom_known && 32'(cmd.chrom_index) < 32'(CHROM_COUNT))
                        begin
                            mask_next[0] = (map_mode_reg == 2'd0) && cmd.first_exon;
                            mask_next[1] = (map_mode_reg == 2'd0) && cmd.first_exon;
                            mask_next[2] = map_mode_reg[0] && cmd.first_exon;
                            mask_next[3] = map_mode_reg[0] && cmd.first_exon;
                            mask_next[4] = map_mode_reg[1] && cmd.first_exon;
                            mask_next[5] = map_mode_reg[1] && cmd.first_exon;
                            mask_next[6] = map_mode_reg[1] && !cmd.first_exon;
                            mask_next[7] = map_mode_reg[1];
                        end
                        state_next = S_NEXT;
                    end
                end
            end
            S_RDREQ:
                state_next = S_RDDATA;
            S_RDDATA:
            begin
                code_next  = read_ok_latched() ? rdata_reg : grbp_pkg::RC_INTERGENIC;
                state_next = S_DONE;
            end
            S_NEXT:
            begin
                if (mask_reg == 8'd0)
                begin
                    prev_tag_next = 1'b1;
                    state_next    = S_DLOAD;
                end
                else
                begin
                    prev_tag_next = 1'b0;
                    for (int i = 7; i >= 0; i--)
                    begin
                        if (mask_reg[i])
                            op_next = 3'(i);
                    end
                    if (mask_reg[0] || mask_reg[1] || mask_reg[2] || mask_reg[3]
                        || mask_reg[4] || mask_reg[5] || !mask_reg[6])
                        slot_next = 2'd0;
                    else
                    begin
                        // The intron starts one bin past the previous exon end.
                        slot_next = 2'd1;
                        lo_next   = $signed({3'd0, prev_reg}) + 31'sd1;
                    end
                    state_next = S_DLOAD;
                end
            end
            S_DLOAD:
            begin
                neg_next   = div_pos < 0;
                mag_next   = (div_pos < 0) ? 29'(-div_pos) : 29'(div_pos);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (cnt_reg == 5'(grbp_pkg::DIV_STEPS))
                begin
                    if (prev_tag_reg)
                    begin
                        prev_next  = quot[27:0];
                        state_next = S_DONE;
                    end
                    else
                    begin
                        unique case (slot_reg)
                            2'd0: lo_next = quot;
                            2'd1: hi_next = quot;
                            2'd2: cs_next = quot;
                            2'd3: ce_next = quot;
                        endcase
                        if (op_reg == grbp_pkg::OP_EXON && slot_reg != 2'd3)
                        begin
                            slot_next  = slot_reg + 2'd1;
                            state_next = S_DLOAD;
                        end
                        else if (op_reg != grbp_pkg::OP_EXON && slot_reg == 2'd0)
                        begin
                            slot_next  = 2'd1;
                            state_next = S_DLOAD;
                        end
                        else
                            state_next = S_WINIT;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                    if (rem_sh >= {1'b0, w_eff})
                    begin
                        rem_next = rem_sh - {1'b0, w_eff};
                        mag_next = {mag_reg[27:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rem_sh;
                        mag_next = {mag_reg[27:0], 1'b0};
                    end
                end
            end
            S_WINIT:
            begin
                if (lo_c < hi_c)
                begin
                    j_next     = lo_c;
                    hic_next   = hi_c;
                    state_next = S_WRD;
                end
                else
                begin
                    mask_next[op_reg] = 1'b0;
                    state_next        = S_NEXT;
                end
            end
            S_WRD:
                state_next = S_WWR;
            S_WWR:
            begin
                if (j_reg + JW'(1) < hic_reg)
                begin
                    j_next     = j_reg + JW'(1);
                    state_next = S_WRD;
                end
                else
                begin
                    mask_next[op_reg] = 1'b0;
                    state_next        = S_NEXT;
                end
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            mask_reg     <= '0;
            op_reg       <= '0;
            slot_reg     <= '0;
            prev_tag_reg <= 1'b0;
            cnt_reg      <= '0;
            prev_reg     <= '0;
            tx_reg       <= '0;
            code_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            mask_reg     <= mask_next;
            op_reg       <= op_next;
            slot_reg     <= slot_next;
            prev_tag_reg <= prev_tag_next;
            cnt_reg      <= cnt_next;
            prev_reg     <= prev_next;
            tx_reg       <= tx_next;
            code_reg     <= code_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        row_base_reg <= row_base_next;
        mag_reg      <= mag_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        cs_reg       <= cs_next;
        ce_reg       <= ce_next;
        j_reg        <= j_next;
        hic_reg      <= hic_next;
    end

    assign busy                    = (state_reg != S_IDLE);
    assign result_valid            = (state_reg == S_DONE);
    assign result.region_code      = code_reg;
    assign result.transcript_count = tx_reg;

endmodule

// ===== sim/grbp_checker.sv =====
// ----------------------------------------------------------------------------
// grbp_checker: scoreboard for the genomic region bin painter
// Follows register writes and accepted transactions, keeps its own copy of
// the region map, predicts each result and compares it with the block.
// ----------------------------------------------------------------------------
module grbp_checker #(
    parameter int CHROM_COUNT    = 32,
    parameter int BINS_PER_CHROM = 16384
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  grbp_pkg::cmd_t    cmd,
    input  logic              result_valid,
    input  grbp_pkg::result_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                pending,
    output int                failures
);

    typedef enum int { GUARD_NONE, GUARD_PROM, GUARD_INTRON } guard_t;

    logic [3:0]        region_map [CHROM_COUNT*BINS_PER_CHROM];
    logic [27:0]       last_end_bin;
    logic [15:0]       tx_seen;
    logic [20:0]       win_res, flank_bp, prom_bp, prox_bp;
    logic [1:0]        paint_mode;
    grbp_pkg::result_t expected_q [$];

    assign pending = expected_q.size();

    function automatic longint to_bin(longint pos);
        longint w;
        w = (win_res == 0) ? 1 : longint'(win_res);
        // Integer division in SystemVerilog truncates toward zero.
        return pos / w;
    endfunction

    function automatic void paint_span(int chrom, longint lo, longint hi,
                                       logic [3:0] code, guard_t guard);
        logic [3:0] v;
        if (lo < 0) lo = 0;
        if (hi > BINS_PER_CHROM) hi = BINS_PER_CHROM;
        for (longint j = lo; j < hi; j++)
        begin
            v = region_map[chrom*BINS_PER_CHROM + int'(j)];
            if (guard == GUARD_PROM && v == grbp_pkg::RC_PROMOTER) continue;
            if (guard == GUARD_INTRON && (v == grbp_pkg::RC_DISTAL
                || v == grbp_pkg::RC_PROXIMAL || v == grbp_pkg::RC_UTR5
                || v == grbp_pkg::RC_UTR3 || v == grbp_pkg::RC_CDS)) continue;
            region_map[chrom*BINS_PER_CHROM + int'(j)] = code;
        end
    endfunction

    function automatic void paint_exon_span(int chrom, longint lo, longint hi,
                                            longint cs, longint ce, bit rev);
        logic [3:0] v;
        int idx;
        if (lo < 0) lo = 0;
        if (hi > BINS_PER_CHROM) hi = BINS_PER_CHROM;
        for (longint j = lo; j < hi; j++)
        begin
            idx = chrom*BINS_PER_CHROM + int'(j);
            v = region_map[idx];
            if (v == grbp_pkg::RC_DISTAL || v == grbp_pkg::RC_PROXIMAL) continue;
            if (j < cs) region_map[idx] = rev ? grbp_pkg::RC_UTR3 : grbp_pkg::RC_UTR5;
            else if (j > ce) region_map[idx] = rev ? grbp_pkg::RC_UTR5 : grbp_pkg::RC_UTR3;
            else region_map[idx] = grbp_pkg::RC_CDS;
        end
    endfunction

    function automatic grbp_pkg::result_t predict_paint(grbp_pkg::cmd_t c);
        grbp_pkg::result_t r;
        longint p1, p2, cp1, cp2, e1, e2, pl, xl, fl;
        int ch;
        bit rev;
        p1 = c.tx_start;   p2 = c.tx_end;
        cp1 = c.cds_start; cp2 = c.cds_end;
        e1 = c.exon_start; e2 = c.exon_end;
        pl = prom_bp; xl = prox_bp; fl = flank_bp;
        ch = c.chrom_index;
        rev = c.strand;
        r.region_code = grbp_pkg::RC_INTERGENIC;
        if (c.mode)
        begin
            if (ch < CHROM_COUNT && c.read_bin < BINS_PER_CHROM)
                r.region_code = region_map[ch*BINS_PER_CHROM + c.read_bin];
        end
        else
        begin
            if (c.first_exon && tx_seen != 16'hFFFF) tx_seen++;
            if (c.chrom_known && ch < CHROM_COUNT)
            begin
                if (paint_mode == 2'd0 && c.first_exon)
                begin
                    if (!rev) paint_span(ch, to_bin(p1 - pl), to_bin(p1),
                                         grbp_pkg::RC_PROMOTER, GUARD_NONE);
                    else paint_span(ch, to_bin(p2), to_bin(p2 + pl),
                                    grbp_pkg::RC_PROMOTER, GUARD_NONE);
                    paint_span(ch, to_bin(p1), to_bin(p2), grbp_pkg::RC_GENIC, GUARD_PROM);
                end
                if (paint_mode[0] && c.first_exon)
                begin
                    if (!rev)
                    begin
                        paint_span(ch, to_bin(p1 - fl), to_bin(p1 + fl),
                                   grbp_pkg::RC_PROMOTER, GUARD_NONE);
                        paint_span(ch, to_bin(p1 + fl), to_bin(p2),
                                   grbp_pkg::RC_GENIC, GUARD_PROM);
                    end
                    else
                    begin
                        paint_span(ch, to_bin(p2 - fl), to_bin(p2 + fl),
                                   grbp_pkg::RC_PROMOTER, GUARD_NONE);
                        paint_span(ch, to_bin(p1), to_bin(p2 - fl),
                                   grbp_pkg::RC_GENIC, GUARD_PROM);
                    end
                end
                if (paint_mode[1])
                begin
                    if (c.first_exon)
                    begin
                        if (!rev)
                        begin
                            longint ed;
                            ed = to_bin(p1 - xl - 1);
                            if (ed < 0) ed = 0;
                            paint_span(ch, to_bin(p1 - pl), ed, grbp_pkg::RC_DISTAL,
                                       GUARD_NONE);
                            paint_span(ch, to_bin(p1 - xl), to_bin(p1),
                                       grbp_pkg::RC_PROXIMAL, GUARD_NONE);
                        end
                        else
                        begin
                            paint_span(ch, to_bin(p2 + xl + 1), to_bin(p2 + pl),
                                       grbp_pkg::RC_DISTAL, GUARD_NONE);
                            paint_span(ch, to_bin(p2), to_bin(p2 + xl),
                                       grbp_pkg::RC_PROXIMAL, GUARD_NONE);
                        end
                    end
                    else
                    begin
                        paint_span(ch, longint'(last_end_bin) + 1, to_bin(e1),
                                   grbp_pkg::RC_INTRON, GUARD_INTRON);
                    end
                    paint_exon_span(ch, to_bin(e1), to_bin(e2), to_bin(cp1), to_bin(cp2),
                                    rev);
                end
            end
            last_end_bin = 28'(to_bin(e2));
        end
        r.transcript_count = tx_seen;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grbp_pkg::result_t exp_r;
        if (!rst_n)
        begin
            foreach (region_map[i]) region_map[i] = grbp_pkg::RC_INTERGENIC;
            last_end_bin = '0;
            tx_seen      = '0;
            win_res      = 21'd1;
            paint_mode   = 2'd0;
            flank_bp     = 21'd1000;
            prom_bp      = 21'd2500;
            prox_bp      = 21'd1000;
            failures     = 0;
            expected_q.delete();
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with no transaction outstanding");
                    failures++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (result.region_code !== exp_r.region_code)
                    begin
                        $error("region_code: expected %0d, actual %0d",
                               exp_r.region_code, result.region_code);
                        failures++;
                    end
                    if (result.transcript_count !== exp_r.transcript_count)
                    begin
                        $error("transcript_count: expected %0d, actual %0d",
                               exp_r.transcript_count, result.transcript_count);
                        failures++;
                    end
                end
            end
            if (start && !busy) expected_q.push_back(predict_paint(cmd));
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    grbp_pkg::REG_WINDOW_RES:     win_res    = pwdata[20:0];
                    grbp_pkg::REG_MAP_MODE:       paint_mode = pwdata[1:0];
                    grbp_pkg::REG_FLANK_SIZE:     flank_bp   = pwdata[20:0];
                    grbp_pkg::REG_PROMOTER_SIZE:  prom_bp    = pwdata[20:0];
                    grbp_pkg::REG_PROXIMAL_POINT: prox_bp    = pwdata[20:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== sim/genomic_region_bin_painter_test.sv =====
// ----------------------------------------------------------------------------
// genomic_region_bin_painter_test: top of the painter regression
// Drives directed and random exon and read transactions through several
// register settings and idle patterns; the checker scores every result.
// ----------------------------------------------------------------------------
module genomic_region_bin_painter_test;

    localparam longint MAX_POS     = 28'hFFFFFFF;
    localparam int     STALL_LIMIT = 3000000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    grbp_pkg::cmd_t    cmd = '0;
    logic              result_valid;
    grbp_pkg::result_t result;
    logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    int                pending, failures;
    int                quiet_cycles = 0;
    int                idle_pct = 0;
    int                phase_items;

    always #4 clk = ~clk;

    genomic_region_bin_painter dut (.*);

    grbp_checker chk (
        .clk, .rst_n, .start, .busy, .cmd, .result_valid, .result,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .pending, .failures
    );

    // No accepted transaction and no result for too long means the block has hung.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Called at a rising edge; returns at the rising edge that took the transaction, or after a random idle gap.
    task automatic issue(grbp_pkg::cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        do @(negedge clk); while (busy);
        @(posedge clk);
        phase_items++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(negedge clk); while (pending != 0 || busy);
        @(posedge clk);
    endtask

    task automatic reg_write(logic [2:0] idx, int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic grbp_pkg::cmd_t exon_cmd(int ch, bit known, bit rev,
                                                longint t0, longint t1,
                                                longint c0, longint c1,
                                                longint e0, longint e1, bit first);
        grbp_pkg::cmd_t c;
        c = '0;
        c.mode = 1'b0;
        c.chrom_index = 5'(ch);
        c.chrom_known = known;
        c.strand = rev;
        c.tx_start = 28'(t0);   c.tx_end = 28'(t1);
        c.cds_start = 28'(c0);  c.cds_end = 28'(c1);
        c.exon_start = 28'(e0); c.exon_end = 28'(e1);
        c.first_exon = first;
        c.read_bin = 14'($urandom_range(16383));
        return c;
    endfunction

    task automatic read_bin_at(int ch, int bin_idx);
        grbp_pkg::cmd_t c;
        c = '0;
        c.mode = 1'b1;
        c.chrom_index = 5'(ch);
        c.read_bin = 14'(bin_idx);
        c.tx_start = 28'($urandom_range(MAX_POS));
        c.exon_end = 28'($urandom_range(MAX_POS));
        issue(c);
    endtask

    // One transcript: exons in order, the first flagged, all within a short span.
    // A broken one leaves out the first exon; reads near the start follow.
    task automatic send_transcript(int unsigned win, bit broken);
        longint w, base, t0, t1, c0, c1, top_base;
        int pts [$];
        int n, ch, base_bin;
        bit rev, known;
        w = (win == 0) ? 1 : win;
        top_base = 15000 * w;
        if (top_base > MAX_POS - 100 * w) top_base = MAX_POS - 100 * w;
        base = $urandom_range(int'(top_base));
        t0 = base;
        t1 = t0 + $urandom_range(1, 60) * w + $urandom_range(int'(w - 1));
        if (t1 > MAX_POS) t1 = MAX_POS;
        c0 = t0 + $urandom_range(int'(t1 - t0));
        c1 = c0 + $urandom_range(int'(t1 - c0));
        n = $urandom_range(1, 4);
        for (int k = 0; k < 2 * n; k++)
            pts.push_back(int'(t0 + $urandom_range(int'(t1 - t0))));
        pts.sort();
        ch = $urandom_range(31);
        rev = 1'($urandom_range(1));
        known = ($urandom_range(15) != 0);
        for (int k = broken ? 1 : 0; k < n; k++)
            issue(exon_cmd(ch, known, rev, t0, t1, c0, c1, pts[2*k], pts[2*k+1], k == 0));
        base_bin = int'(base / w);
        read_bin_at(ch, base_bin);
        read_bin_at(ch, int'((base_bin + $urandom_range(70)) % 16384));
        if (base_bin > 70) read_bin_at(ch, base_bin - int'($urandom_range(70)));
    endtask

    // Random fields everywhere; the chromosome is unknown unless the window is wide, and then known at random.
    task automatic send_noise(int unsigned win);
        grbp_pkg::cmd_t c;
        c = exon_cmd($urandom_range(31), win >= 65536 && $urandom_range(1),
                     1'($urandom_range(1)),
                     $urandom_range(MAX_POS), $urandom_range(MAX_POS),
                     $urandom_range(MAX_POS), $urandom_range(MAX_POS),
                     $urandom_range(MAX_POS), $urandom_range(MAX_POS),
                     1'($urandom_range(1)));
        if ($urandom_range(3) == 0) c.mode = 1'b1;
        issue(c);
    endtask

    int unsigned cfg_win   [6] = '{100, 50, 200, 1, 1048576, 0};
    int unsigned cfg_mode  [6] = '{0, 1, 2, 3, 3, 2};
    int unsigned cfg_flank [6] = '{2000, 1000, 3000, 40, 1048576, 1};
    int unsigned cfg_prom  [6] = '{2500, 1500, 5000, 60, 1048576, 0};
    int unsigned cfg_prox  [6] = '{1000, 500, 2000, 20, 1048576, 0};
    int          idle_sched [3] = '{0, 79, 34};

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with the reset register values.
        issue(exon_cmd(0, 1, 0, 5000, 5100, 5020, 5080, 5000, 5040, 1));
        issue(exon_cmd(0, 1, 0, 5000, 5100, 5020, 5080, 5060, 5100, 0));
        read_bin_at(0, 3000);
        read_bin_at(0, 5050);
        read_bin_at(0, 0);
        issue(exon_cmd(1, 1, 1, 9000, 9050, 9010, 9040, 9000, 9050, 1));
        read_bin_at(1, 10000);
        read_bin_at(1, 9020);
        issue(exon_cmd(2, 0, 0, 7000, 7100, 7000, 7100, 7000, 7100, 1));
        read_bin_at(2, 7050);
        issue(exon_cmd(31, 1, 1, MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS, 1));
        issue(exon_cmd(0, 1, 0, 0, 0, 0, 0, 0, 0, 1));
        issue(exon_cmd(3, 1, 0, 300, 200, 300, 200, 300, 200, 1));
        read_bin_at(31, 16383);
        read_bin_at(31, 0);
        read_bin_at(3, 250);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            reg_write(grbp_pkg::REG_WINDOW_RES, cfg_win[ph]);
            reg_write(grbp_pkg::REG_MAP_MODE, cfg_mode[ph]);
            reg_write(grbp_pkg::REG_FLANK_SIZE, cfg_flank[ph]);
            reg_write(grbp_pkg::REG_PROMOTER_SIZE, cfg_prom[ph]);
            reg_write(grbp_pkg::REG_PROXIMAL_POINT, cfg_prox[ph]);
            idle_pct = idle_sched[ph % 3];
            phase_items = 0;
            while (phase_items < 140)
            begin
                if ($urandom_range(9) == 0) send_noise(cfg_win[ph]);
                else send_transcript(cfg_win[ph],
                                     cfg_win[ph] >= 1024 && $urandom_range(4) == 0);
                // Partway through each phase, let the block run dry before going on.
                if (phase_items >= 70 && phase_items < 76) drain();
            end
        end

        drain();
        repeat (200) @(posedge clk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
